>>> hw/rtl/tms_pkg.sv
`default_nettype none

package tms_pkg;

    // machine size
    localparam int TAPE_CELLS = 1024;
    localparam int RULE_SLOTS = 64;
    localparam int STATE_BITS = 8;

    // field widths
    localparam int CMD_W    = 3;
    localparam int SLOT_W   = $clog2(RULE_SLOTS);
    localparam int STATE_W  = STATE_BITS;
    localparam int MOVE_W   = 2;
    localparam int ADDR_W   = $clog2(TAPE_CELLS);
    localparam int STATUS_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_RULE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_CELL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STEP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_CELL  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STEPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_RULE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OFF_TAPE = 3'd4;

    // head move codes, anything else halts
    localparam logic [MOVE_W-1:0] MOVE_UP   = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_DOWN = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  rule_slot;
        logic               rule_valid;
        logic [STATE_W-1:0] rule_match_state;
        logic               rule_match_bit;
        logic               rule_write_bit;
        logic [MOVE_W-1:0]  rule_move;
        logic [STATE_W-1:0] rule_next_state;
        logic [ADDR_W-1:0]  cell_addr;
        logic               cell_bit;
    } tms_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                read_bit;
        logic [ADDR_W-1:0]   head_pos;
        logic [STATE_W-1:0]  machine_state;
    } tms_rsp_t;

    typedef struct packed {
        logic [STATE_W-1:0] match_state;
        logic               match_bit;
        logic               write_bit;
        logic [MOVE_W-1:0]  move;
        logic [STATE_W-1:0] next_state;
    } rule_t;

    // controller to datapath
    typedef struct packed {
        logic                capture;
        logic                load_rule;
        logic                write_cell;
        logic                restart;
        logic                tape_rd_addr;
        logic                latch_rbit;
        logic                scan_start;
        logic                scan_run;
        logic                apply;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                out_load;
    } tms_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] req_cmd;
        logic             stopped;
        logic             clear_busy;
        logic             hit;
        logic             miss_last;
    } tms_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/tms_if.sv
`default_nettype none

interface tms_req_if;
    import tms_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_W-1:0]   rule_slot;
    logic                rule_valid;
    logic [STATE_W-1:0]  rule_match_state;
    logic                rule_match_bit;
    logic                rule_write_bit;
    logic [MOVE_W-1:0]   rule_move;
    logic [STATE_W-1:0]  rule_next_state;
    logic [ADDR_W-1:0]   cell_addr;
    logic                cell_bit;

    modport source (
        output valid, cmd, rule_slot, rule_valid, rule_match_state, rule_match_bit,
               rule_write_bit, rule_move, rule_next_state, cell_addr, cell_bit,
        input  ready
    );

    modport sink (
        input  valid, cmd, rule_slot, rule_valid, rule_match_state, rule_match_bit,
               rule_write_bit, rule_move, rule_next_state, cell_addr, cell_bit,
        output ready
    );
endinterface

interface tms_rsp_if;
    import tms_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                read_bit;
    logic [ADDR_W-1:0]   head_pos;
    logic [STATE_W-1:0]  machine_state;

    modport source (
        output valid, status, read_bit, head_pos, machine_state,
        input  ready
    );

    modport sink (
        input  valid, status, read_bit, head_pos, machine_state,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/tms_ctrl.sv
`default_nettype none

module tms_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire tms_pkg::tms_stat_t  stat,
    output tms_pkg::tms_cmd_t        cmd
);
    import tms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // take a request only when idle and the tape clear pass is over
    assign in_ready  = (state_reg == S_IDLE) && !stat.clear_busy;
    assign out_valid = out_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.req_cmd)
                    CMD_LOAD_RULE:
                    begin
                        cmd.load_rule  = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_DONE;
                        state_next     = S_RESULT;
                    end
                    CMD_WRITE_CELL:
                    begin
                        cmd.write_cell = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_DONE;
                        state_next     = S_RESULT;
                    end
                    CMD_RESTART:
                    begin
                        cmd.restart    = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_DONE;
                        state_next     = S_RESULT;
                    end
                    CMD_STEP:
                    begin
                        if (stat.stopped)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_HALTED;
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    CMD_READ_CELL:
                    begin
                        cmd.tape_rd_addr = 1'b1;
                        state_next       = S_READ;
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_DONE;
                        state_next     = S_RESULT;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.latch_rbit = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_DONE;
                state_next     = S_RESULT;
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_RESULT;
                end
                else if (stat.miss_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NO_RULE;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a rule match is only seen while scanning
    a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        stat.hit |-> state_reg == S_SCAN)
        else $error("rule match outside scan");

    // execution starts only after an accepted request
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(in_valid && in_ready))
        else $error("exec without accepted request");

    // nothing in flight during the tape clear pass
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clear_busy |-> (state_reg == S_IDLE) && !out_valid_reg)
        else $error("activity during tape clear");

endmodule

`default_nettype wire

>>> hw/rtl/tms_datapath.sv
`default_nettype none

module tms_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tms_pkg::tms_req_t        req_in,
    input  wire logic                     cfg_we,
    input  wire logic [tms_pkg::STATE_W-1:0] cfg_wdata,
    input  wire tms_pkg::tms_cmd_t        cmd,
    output tms_pkg::tms_stat_t            stat,
    output tms_pkg::tms_rsp_t             rsp
);
    import tms_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RULE_SLOTS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(TAPE_CELLS - 1);

    tms_req_t            req_reg;
    logic [STATE_W-1:0]  start_state_reg;
    logic [STATE_W-1:0]  cur_state_reg;
    logic [ADDR_W-1:0]   head_reg;
    logic                stopped_reg;
    logic [RULE_SLOTS-1:0] valid_reg;
    rule_t               rule_mem [RULE_SLOTS];
    logic                tape_mem [TAPE_CELLS];
    logic                clr_busy_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                tape_q_reg;
    logic [SLOT_W-1:0]   scan_idx_reg;
    logic                scan_on_reg;
    rule_t               rule_q_reg;
    logic                cmp_live_reg;
    logic                cmp_vld_reg;
    logic                cmp_last_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                rbit_reg;
    tms_rsp_t            rsp_reg;

    logic                rd_issue;
    logic [SLOT_W-1:0]   rd_slot;
    logic                hit;
    logic                tape_we;
    logic [ADDR_W-1:0]   tape_waddr;
    logic                tape_wdata;
    logic                tape_re;
    logic [ADDR_W-1:0]   tape_raddr;
    logic [STATUS_W-1:0] apply_status;
    logic [ADDR_W-1:0]   apply_head;
    logic [STATE_W-1:0]  apply_state;
    logic                apply_stop;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req_in;
    end

    // start state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_state_reg <= STATE_W'(1);
        else if (cfg_we)
            start_state_reg <= cfg_wdata;
    end

    // rule match against the registered slot
    assign hit = cmp_live_reg && cmp_vld_reg
              && (rule_q_reg.match_state == cur_state_reg)
              && (rule_q_reg.match_bit == tape_q_reg);

    // effect of the matched rule
    always_comb
    begin
        apply_head  = head_reg;
        apply_state = cur_state_reg;
        apply_stop  = 1'b0;
        case (rule_q_reg.move)
            MOVE_UP:
            begin
                apply_state = rule_q_reg.next_state;
                if (head_reg == LAST_CELL)
                begin
                    apply_stop   = 1'b1;
                    apply_status = ST_OFF_TAPE;
                end
                else
                begin
                    apply_head   = head_reg + 1'b1;
                    apply_status = ST_STEPPED;
                end
            end
            MOVE_DOWN:
            begin
                apply_state = rule_q_reg.next_state;
                if (head_reg == '0)
                begin
                    apply_stop   = 1'b1;
                    apply_status = ST_OFF_TAPE;
                end
                else
                begin
                    apply_head   = head_reg - 1'b1;
                    apply_status = ST_STEPPED;
                end
            end
            default:
            begin
                apply_stop   = 1'b1;
                apply_status = ST_HALTED;
            end
        endcase
    end

    // head, machine state and stop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cur_state_reg <= STATE_W'(1);
            stopped_reg   <= 1'b0;
        end
        else if (cmd.restart)
        begin
            head_reg      <= '0;
            cur_state_reg <= start_state_reg;
            stopped_reg   <= 1'b0;
        end
        else if (cmd.apply)
        begin
            head_reg      <= apply_head;
            cur_state_reg <= apply_state;
            stopped_reg   <= apply_stop;
        end
    end

    // status and read bit of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.set_status)
            status_reg <= cmd.status;
        else if (cmd.apply)
            status_reg <= apply_status;

        if (cmd.capture)
            rbit_reg <= 1'b0;
        else if (cmd.latch_rbit)
            rbit_reg <= tape_q_reg;
    end

    // rule valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.load_rule)
            valid_reg[req_reg.rule_slot] <= req_reg.rule_valid;
    end

    // rule scan read address, one slot per cycle
    assign rd_issue = cmd.scan_start || (cmd.scan_run && scan_on_reg);
    assign rd_slot  = cmd.scan_start ? '0 : scan_idx_reg;

    // rule memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_rule)
            rule_mem[req_reg.rule_slot] <= '{
                match_state: req_reg.rule_match_state,
                match_bit:   req_reg.rule_match_bit,
                write_bit:   req_reg.rule_write_bit,
                move:        req_reg.rule_move,
                next_state:  req_reg.rule_next_state
            };
        if (rd_issue)
            rule_q_reg <= rule_mem[rd_slot];
    end

    // scan sequencing and compare stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            scan_on_reg  <= 1'b0;
            cmp_live_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            cmp_last_reg <= 1'b0;
        end
        else if (rd_issue)
        begin
            scan_idx_reg <= rd_slot + 1'b1;
            scan_on_reg  <= (rd_slot != LAST_SLOT);
            cmp_live_reg <= 1'b1;
            cmp_vld_reg  <= valid_reg[rd_slot];
            cmp_last_reg <= (rd_slot == LAST_SLOT);
        end
        else
        begin
            cmp_live_reg <= 1'b0;
        end
    end

    // tape clear pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_CELL)
                clr_busy_reg <= 1'b0;
        end
    end

    // tape write and read port selection
    always_comb
    begin
        tape_we    = 1'b0;
        tape_waddr = head_reg;
        tape_wdata = rule_q_reg.write_bit;
        if (clr_busy_reg)
        begin
            tape_we    = 1'b1;
            tape_waddr = clr_addr_reg;
            tape_wdata = 1'b0;
        end
        else if (cmd.write_cell)
        begin
            tape_we    = 1'b1;
            tape_waddr = req_reg.cell_addr;
            tape_wdata = req_reg.cell_bit;
        end
        else if (cmd.apply)
        begin
            tape_we = 1'b1;
        end
    end

    assign tape_re    = cmd.scan_start || cmd.tape_rd_addr;
    assign tape_raddr = cmd.tape_rd_addr ? req_reg.cell_addr : head_reg;

    // tape memory
    always_ff @(posedge clk)
    begin
        if (tape_we)
            tape_mem[tape_waddr] <= tape_wdata;
        if (tape_re)
            tape_q_reg <= tape_mem[tape_raddr];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            rsp_reg <= '{
                status:        status_reg,
                read_bit:      rbit_reg,
                head_pos:      head_reg,
                machine_state: cur_state_reg
            };
    end

    assign rsp = rsp_reg;

    assign stat = '{
        req_cmd:    req_reg.cmd,
        stopped:    stopped_reg,
        clear_busy: clr_busy_reg,
        hit:        hit,
        miss_last:  cmp_live_reg && cmp_last_reg && !hit
    };

    // no tape or rule traffic from requests while clearing
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !(cmd.load_rule || cmd.write_cell || cmd.apply || cmd.scan_start))
        else $error("request work during tape clear");

    // the machine stops only when a rule is applied
    a_stop_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stopped_reg) |-> $past(cmd.apply))
        else $error("stop flag set without rule");

    // the scan ends after the last slot
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmp_live_reg && cmp_last_reg && !cmd.scan_start) |=> !cmp_live_reg)
        else $error("scan ran past last slot");

endmodule

`default_nettype wire

>>> hw/rtl/turing_machine_stepper_top.sv
`default_nettype none

// Binary-tape Turing machine stepper. Each request on req_ch (load rule, write
// cell, restart, step, read cell) gives exactly one response on rsp_ch with a
// status, the read bit, the head position and the machine state after the
// request. After reset the tape is cleared by a pass over all 1024 cells, one
// cell per cycle, during which req_ch.ready stays low; cfg_we writes the start
// state at any time and is applied on the next restart. Requests are worked
// one at a time: load, write, restart, unknown commands and a step while halted
// pass through the execute and result states, a read adds a tape read state
// between them, and a step adds a scan state between them for the rule search,
// since the 64-entry rule memory is read one slot per cycle in index order until
// the first valid match. A new request is accepted while the previous response
// still waits in the output register.
module turing_machine_stepper_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tms_req_if.sink                           req_ch,
    tms_rsp_if.source                         rsp_ch,
    input  wire logic                         cfg_we,
    input  wire logic [tms_pkg::STATE_W-1:0]  cfg_wdata
);
    import tms_pkg::*;

    tms_req_t  req_in;
    tms_rsp_t  rsp;
    tms_cmd_t  cmd;
    tms_stat_t stat;

    // request payload
    assign req_in = '{
        cmd:              req_ch.cmd,
        rule_slot:        req_ch.rule_slot,
        rule_valid:       req_ch.rule_valid,
        rule_match_state: req_ch.rule_match_state,
        rule_match_bit:   req_ch.rule_match_bit,
        rule_write_bit:   req_ch.rule_write_bit,
        rule_move:        req_ch.rule_move,
        rule_next_state:  req_ch.rule_next_state,
        cell_addr:        req_ch.cell_addr,
        cell_bit:         req_ch.cell_bit
    };

    tms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_ch.valid),
        .in_ready  (req_ch.ready),
        .out_valid (rsp_ch.valid),
        .out_ready (rsp_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tms_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_in    (req_in),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

    // response payload
    assign rsp_ch.status        = rsp.status;
    assign rsp_ch.read_bit      = rsp.read_bit;
    assign rsp_ch.head_pos      = rsp.head_pos;
    assign rsp_ch.machine_state = rsp.machine_state;

endmodule

`default_nettype wire
